>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the point projector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("projector assertion failed");
`define PPP_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("projector assertion failed");
`else
`define PPP_ASSERT(label, prop)
`define PPP_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hw/rtl/ppp_pkg.sv
// Shared types and constants of the perspective point projector.
package ppp_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int NSLOTS         = 12;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_PROJ = 1'b1;

	localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
	localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
	localparam logic [2:0] REG_VIEW_WIDTH  = 3'd2;
	localparam logic [2:0] REG_VIEW_HEIGHT = 3'd3;
	localparam logic [2:0] REG_W_THRESHOLD = 3'd4;

	typedef struct packed {
		logic               action;
		logic        [3:0]  coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_t;

	typedef struct packed {
		logic               on_screen;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} out_t;

	typedef struct packed {
		logic valid;
		logic vis;
	} ctl_t;

endpackage

>>> hw/rtl/ppp_dot.sv
// Coefficient store and three-stage row dot products (clip x, y, w).
module ppp_dot #(
	parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = ppp_pkg::WORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         load,
	input  logic [3:0]                   load_index,
	input  logic signed [31:0]           load_value,
	input  logic                         proj,
	input  logic signed [31:0]           point_x,
	input  logic signed [31:0]           point_y,
	input  logic signed [31:0]           point_z,
	output logic                         valid,
	output logic signed [WORD_WIDTH-1:0] clip_x,
	output logic signed [WORD_WIDTH-1:0] clip_y,
	output logic signed [WORD_WIDTH-1:0] clip_w
);
	localparam int SW = ((WORD_WIDTH > 32) ? WORD_WIDTH : 32) + 2;
	localparam logic signed [63:0] BIAS = 64'((64'sd1 <<< FRAC_BITS) - 64'sd1);
	localparam logic signed [63:0] HI64 =
		{{(65 - WORD_WIDTH){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
	localparam logic signed [63:0] LO64 = ~HI64;
	localparam logic signed [SW-1:0] HIS =
		{{(SW - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] LOS = ~HIS;

	function automatic logic signed [WORD_WIDTH-1:0] qsat(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p[63] ? ((p + BIAS) >>> FRAC_BITS) : (p >>> FRAC_BITS);
		if (t > HI64) t = HI64;
		else if (t < LO64) t = LO64;
		return t[WORD_WIDTH-1:0];
	endfunction

	function automatic logic signed [WORD_WIDTH-1:0] ssat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] t;
		t = s;
		if (t > HIS) t = HIS;
		else if (t < LOS) t = LOS;
		return t[WORD_WIDTH-1:0];
	endfunction

	logic        [31:0] coef_q [ppp_pkg::NSLOTS];
	logic signed [31:0] pt [3];

	logic                         valid_s1, valid_s2, valid_s3;
	logic signed [63:0]           prod_s1 [9];
	logic signed [31:0]           off_s1 [3];
	logic signed [WORD_WIDTH-1:0] prod_s2 [9];
	logic signed [31:0]           off_s2 [3];
	logic signed [WORD_WIDTH-1:0] sum_s3 [3];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppp_pkg::NSLOTS; i++) coef_q[i] <= '0;
		end else if (load && (load_index < 4'(ppp_pkg::NSLOTS))) begin
			coef_q[load_index] <= load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= proj;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= $signed(coef_q[r*4+c]) * pt[c];
				end
				off_s1[r] <= $signed(coef_q[r*4+3]);
			end
			for (int k = 0; k < 9; k++) prod_s2[k] <= qsat(prod_s1[k]);
			for (int r = 0; r < 3; r++) begin
				off_s2[r] <= off_s1[r];
				sum_s3[r] <= ssat(SW'(prod_s2[r*3]) + SW'(prod_s2[r*3+1])
					+ SW'(prod_s2[r*3+2]) + SW'(off_s2[r]));
			end
		end
	end

	assign valid  = valid_s3;
	assign clip_x = sum_s3[0];
	assign clip_y = sum_s3[1];
	assign clip_w = sum_s3[2];
endmodule

>>> hw/rtl/ppp_div.sv
// Visibility test and pipelined restoring dividers for clip x / w and clip y / w.
module ppp_div #(
	parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = ppp_pkg::WORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic signed [WORD_WIDTH-1:0] clip_x,
	input  logic signed [WORD_WIDTH-1:0] clip_y,
	input  logic signed [WORD_WIDTH-1:0] clip_w,
	input  logic [30:0]                  w_threshold,
	output ppp_pkg::ctl_t                ctl,
	output logic signed [WORD_WIDTH-1:0] ndc_x,
	output logic signed [WORD_WIDTH-1:0] ndc_y
);
	localparam int W  = WORD_WIDTH;
	localparam int QB = WORD_WIDTH + FRAC_BITS;
	localparam int TW = ((WORD_WIDTH > 32) ? WORD_WIDTH : 32) + 1;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] MINV = ~MAXV;

	logic [W-1:0] ux, uy;
	logic         vis;

	ppp_pkg::ctl_t ctl_s  [QB+1];
	logic          negx_s [QB+1];
	logic          negy_s [QB+1];
	logic [W-1:0]  den_s  [QB+1];
	logic [W-2:0]  remx_s [QB+1];
	logic [W-2:0]  remy_s [QB+1];
	logic [QB-1:0] dvdx_s [QB+1];
	logic [QB-1:0] dvdy_s [QB+1];

	ppp_pkg::ctl_t          ctl_sn;
	logic signed [W-1:0]    ndc_x_sn, ndc_y_sn;
	logic                   bigx, bigy;

	assign ux  = clip_x;
	assign uy  = clip_y;
	assign vis = ($signed(TW'(clip_w)) >= $signed(TW'({1'b0, w_threshold})))
		&& (clip_w > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) ctl_s[k] <= '0;
			ctl_sn <= '0;
		end else if (en) begin
			ctl_s[0] <= '{valid: valid_in, vis: vis};
			for (int k = 0; k < QB; k++) ctl_s[k+1] <= ctl_s[k];
			ctl_sn <= ctl_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s[0] <= clip_x[W-1];
			negy_s[0] <= clip_y[W-1];
			den_s[0]  <= clip_w;
			remx_s[0] <= '0;
			remy_s[0] <= '0;
			dvdx_s[0] <= {(clip_x[W-1] ? (~ux + W'(1)) : ux), {FRAC_BITS{1'b0}}};
			dvdy_s[0] <= {(clip_y[W-1] ? (~uy + W'(1)) : uy), {FRAC_BITS{1'b0}}};
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [W-1:0] rnx, rny, dfx, dfy;
		logic         gex, gey;
		assign rnx = {remx_s[k], dvdx_s[k][QB-1]};
		assign rny = {remy_s[k], dvdy_s[k][QB-1]};
		assign dfx = rnx - den_s[k];
		assign dfy = rny - den_s[k];
		assign gex = rnx >= den_s[k];
		assign gey = rny >= den_s[k];
		always_ff @(posedge clk) begin
			if (en) begin
				negx_s[k+1] <= negx_s[k];
				negy_s[k+1] <= negy_s[k];
				den_s[k+1]  <= den_s[k];
				remx_s[k+1] <= gex ? dfx[W-2:0] : rnx[W-2:0];
				remy_s[k+1] <= gey ? dfy[W-2:0] : rny[W-2:0];
				dvdx_s[k+1] <= {dvdx_s[k][QB-2:0], gex};
				dvdy_s[k+1] <= {dvdy_s[k][QB-2:0], gey};
			end
		end
	end

	assign bigx = dvdx_s[QB][QB-1:W-1] != '0;
	assign bigy = dvdy_s[QB][QB-1:W-1] != '0;

	always_ff @(posedge clk) begin
		if (en) begin
			if (negx_s[QB]) ndc_x_sn <= bigx ? MINV : $signed(~dvdx_s[QB][W-1:0] + W'(1));
			else            ndc_x_sn <= bigx ? MAXV : $signed(dvdx_s[QB][W-1:0]);
			if (negy_s[QB]) ndc_y_sn <= bigy ? MINV : $signed(~dvdy_s[QB][W-1:0] + W'(1));
			else            ndc_y_sn <= bigy ? MAXV : $signed(dvdy_s[QB][W-1:0]);
		end
	end

	assign ctl   = ctl_sn;
	assign ndc_x = ndc_x_sn;
	assign ndc_y = ndc_y_sn;
endmodule

>>> hw/rtl/ppp_view.sv
// Viewport mapping: scale, half offset, origin and 32-bit saturation.
module ppp_view #(
	parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = ppp_pkg::WORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ppp_pkg::ctl_t                ctl,
	input  logic signed [WORD_WIDTH-1:0] ndc_x,
	input  logic signed [WORD_WIDTH-1:0] ndc_y,
	input  logic signed [15:0]           view_left,
	input  logic signed [15:0]           view_top,
	input  logic [13:0]                  view_width,
	input  logic [13:0]                  view_height,
	output logic                         valid,
	output ppp_pkg::out_t                result
);
	localparam int PW = WORD_WIDTH + 15;
	localparam int XW = ((PW > 17 + FRAC_BITS) ? PW : 17 + FRAC_BITS) + 2;
	localparam logic signed [XW-1:0] ONE =
		{{(XW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [XW-1:0] HI32 = {{(XW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XW-1:0] LO32 = ~HI32;

	function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] t;
		t = v;
		if (t > HI32) t = HI32;
		else if (t < LO32) t = LO32;
		return t[31:0];
	endfunction

	ppp_pkg::ctl_t        ctl_s1;
	logic signed [PW-1:0] px_s1, py_s1;
	logic                 valid_s2;
	ppp_pkg::out_t        res_s2;
	logic signed [XW-1:0] hx, hy, lx, ty, fx, fy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			ctl_s1   <= ctl;
			valid_s2 <= ctl_s1.valid;
		end
	end

	assign hx = $signed(XW'({1'b0, view_width[13:1]})) <<< FRAC_BITS;
	assign hy = $signed(XW'({1'b0, view_height[13:1]})) <<< FRAC_BITS;
	assign lx = XW'(view_left) <<< FRAC_BITS;
	assign ty = XW'(view_top) <<< FRAC_BITS;
	assign fx = (XW'(px_s1) + ONE) >>> 1;
	assign fy = (XW'(py_s1) + ONE) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= ndc_x * $signed({1'b0, view_width});
			py_s1 <= ndc_y * $signed({1'b0, view_height});
			if (ctl_s1.vis) begin
				res_s2.on_screen <= 1'b1;
				res_s2.screen_x  <= sat32(hx + fx + lx);
				res_s2.screen_y  <= sat32(hy - fy + ty);
			end else begin
				res_s2 <= '0;
			end
		end
	end

	assign valid  = valid_s2;
	assign result = res_s2;
endmodule

>>> hw/rtl/perspective_point_projection_top.sv
// Top level of the perspective point projector: config, pipeline and output skid.
//
// Input channel in_valid / in_stall / in_data carries one beat per item. A beat with
// action load writes one coefficient (slots 12..15 are dropped) and yields no result;
// a beat with action project yields exactly one result beat on out_valid / out_stall /
// out_data, in input order.
// Configuration: cfg_we writes cfg_data to the register at cfg_index (0 left, 1 top,
// 2 width, 3 height, 4 w threshold); write only while the pipeline is empty.
// Throughput: one beat per cycle while in_stall is low. The depth of the pipeline is
// set mostly by the one-bit-per-stage restoring dividers that compute clip / w.
// Reset clears the coefficient store to zero, loads the register reset values and
// empties the pipeline.
// When the receiver stalls, the output register holds its beat and one more beat
// lands in the skid register; in_stall rises only while the skid register is full,
// and then the whole pipeline holds.
`include "assert_macros.svh"
module perspective_point_projection_top #(
	parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = ppp_pkg::WORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ppp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output ppp_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data
);
	logic signed [15:0] view_left_q, view_top_q;
	logic [13:0]        view_width_q, view_height_q;
	logic [30:0]        w_threshold_q;

	logic                         en, accept;
	logic                         dot_valid, view_valid;
	logic signed [WORD_WIDTH-1:0] clip_x, clip_y, clip_w, ndc_x, ndc_y;
	ppp_pkg::ctl_t                div_ctl;
	ppp_pkg::out_t                view_res, out_q, skid_q;
	logic                         out_valid_q, skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= '0;
			view_top_q    <= '0;
			view_width_q  <= 14'd1920;
			view_height_q <= 14'd1080;
			w_threshold_q <= 31'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppp_pkg::REG_VIEW_LEFT:   view_left_q   <= cfg_data[15:0];
				ppp_pkg::REG_VIEW_TOP:    view_top_q    <= cfg_data[15:0];
				ppp_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_data[13:0];
				ppp_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_data[13:0];
				ppp_pkg::REG_W_THRESHOLD: w_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;

	ppp_dot #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_dot (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.load       (accept && (in_data.action == ppp_pkg::ACT_LOAD)),
		.load_index (in_data.coef_index),
		.load_value (in_data.coef_value),
		.proj       (accept && (in_data.action == ppp_pkg::ACT_PROJ)),
		.point_x    (in_data.point_x),
		.point_y    (in_data.point_y),
		.point_z    (in_data.point_z),
		.valid      (dot_valid),
		.clip_x     (clip_x),
		.clip_y     (clip_y),
		.clip_w     (clip_w)
	);

	ppp_div #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (dot_valid),
		.clip_x      (clip_x),
		.clip_y      (clip_y),
		.clip_w      (clip_w),
		.w_threshold (w_threshold_q),
		.ctl         (div_ctl),
		.ndc_x       (ndc_x),
		.ndc_y       (ndc_y)
	);

	ppp_view #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_view (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl         (div_ctl),
		.ndc_x       (ndc_x),
		.ndc_y       (ndc_y),
		.view_left   (view_left_q),
		.view_top    (view_top_q),
		.view_width  (view_width_q),
		.view_height (view_height_q),
		.valid       (view_valid),
		.result      (view_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			if (!out_valid_q || !out_stall) out_valid_q <= view_valid;
			else if (view_valid) skid_valid_q <= 1'b1;
		end else if (!out_stall) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			if (!out_valid_q || !out_stall) out_q <= view_res;
			else if (view_valid) skid_q <= view_res;
		end else if (!out_stall) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PPP_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_q |-> out_valid_q)
	`PPP_ASSERT(a_skid_fills, (out_valid_q && out_stall && view_valid && !skid_valid_q) |=> skid_valid_q)
	`PPP_ASSERT(a_off_zero, (out_valid && !out_data.on_screen) |-> (out_data.screen_x == 0 && out_data.screen_y == 0))
endmodule

>>> tb/sv/tb_perspective_point_projection_top.sv
// Self-checking testbench of the perspective point projector: directed table, then random.
`timescale 1ns / 100ps
module tb_perspective_point_projection_top;

	localparam int LATENCY = 55;
	localparam int WATCHDOG = 20000;

	typedef struct {
		ppp_pkg::in_t  beat;
		logic          chk;
		ppp_pkg::out_t res;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	ppp_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_stall;
	ppp_pkg::out_t out_data;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [30:0]   cfg_data;

	logic [31:0]    coef_mem [ppp_pkg::NSLOTS];
	longint         vp_left, vp_top, vp_width, vp_height, w_min;
	ppp_pkg::out_t  pending_q [$];
	int             errors;
	int             idle_cycles;
	bit             quiet;
	bit             hold_long;
	int             sent_cnt;

	perspective_point_projection_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		longint m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = m >>> 16;
		return clamp32((p < 0) ? -m : m);
	endfunction

	function automatic longint row_dot(int r, longint x, longint y, longint z);
		longint s;
		s = fx_mul(longint'($signed(coef_mem[r*4])), x)
			+ fx_mul(longint'($signed(coef_mem[r*4+1])), y)
			+ fx_mul(longint'($signed(coef_mem[r*4+2])), z)
			+ longint'($signed(coef_mem[r*4+3]));
		return clamp32(s);
	endfunction

	function automatic longint fx_div(longint num, longint den);
		longint unsigned mag, q, r, d;
		bit neg;
		neg = num < 0;
		mag = neg ? longint'(-num) : num;
		d = den;
		q = mag / d;
		r = mag % d;
		if (q > 64'd32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		return clamp32(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint floor_div2(longint v);
		if (v >= 0) return v / 2;
		return -((-v + 1) / 2);
	endfunction

	function automatic void project_point(ppp_pkg::in_t b, output bit has,
		output ppp_pkg::out_t res);
		longint cx, cy, cw, nx, ny, sx, sy;
		has = 0;
		res = '0;
		if (b.action == ppp_pkg::ACT_LOAD) begin
			if (b.coef_index < ppp_pkg::NSLOTS) coef_mem[b.coef_index] = b.coef_value;
			return;
		end
		has = 1;
		cx = row_dot(0, b.point_x, b.point_y, b.point_z);
		cy = row_dot(1, b.point_x, b.point_y, b.point_z);
		cw = row_dot(2, b.point_x, b.point_y, b.point_z);
		if (cw < w_min || cw <= 0) return;
		nx = fx_div(cx, cw);
		ny = fx_div(cy, cw);
		sx = (vp_width / 2) * 65536 + floor_div2(nx * vp_width + 65536) + vp_left * 65536;
		sy = (vp_height / 2) * 65536 - floor_div2(ny * vp_height + 65536) + vp_top * 65536;
		res.on_screen = 1'b1;
		res.screen_x = 32'(clamp32(sx));
		res.screen_y = 32'(clamp32(sy));
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ppp_pkg::REG_VIEW_LEFT:   vp_left = longint'($signed(val[15:0]));
			ppp_pkg::REG_VIEW_TOP:    vp_top = longint'($signed(val[15:0]));
			ppp_pkg::REG_VIEW_WIDTH:  vp_width = val[13:0];
			ppp_pkg::REG_VIEW_HEIGHT: vp_height = val[13:0];
			ppp_pkg::REG_W_THRESHOLD: w_min = val;
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_beat(ppp_pkg::in_t b, logic chk, ppp_pkg::out_t typed);
		bit has;
		ppp_pkg::out_t res;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		project_point(b, has, res);
		if (has) pending_q.push_back(chk ? typed : res);
		sent_cnt++;
		@(negedge clk);
	endtask

	function automatic ppp_pkg::in_t load_beat(int idx, logic [31:0] v);
		ppp_pkg::in_t b;
		b = ppp_pkg::in_t'($bits(ppp_pkg::in_t)'({$urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom}));
		b.action = ppp_pkg::ACT_LOAD;
		b.coef_index = 4'(idx);
		b.coef_value = v;
		return b;
	endfunction

	function automatic ppp_pkg::in_t proj_beat(logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		ppp_pkg::in_t b;
		b = ppp_pkg::in_t'($bits(ppp_pkg::in_t)'({$urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom}));
		b.action = ppp_pkg::ACT_PROJ;
		b.point_x = x;
		b.point_y = y;
		b.point_z = z;
		return b;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
		endcase
	endfunction

	task automatic run_random(int n);
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 4) == 0) begin
				for (int s = 0; s < ppp_pkg::NSLOTS; s++) begin
					logic [31:0] v;
					v = (s == 11) ? 32'h0001_0000 + $urandom_range(0, 32'h0004_0000)
						: ($urandom_range(0, 7) == 0 ? $urandom
						: $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
					send_beat(load_beat($urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
						: s, v), 1'b0, '0);
				end
			end
			send_beat(proj_beat(rand_coord(), rand_coord(), rand_coord()), 1'b0, '0);
			k++;
		end
	endtask

	initial begin
		row_t rows [$];
		ppp_pkg::out_t z;
		z = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = ppp_pkg::REG_VIEW_LEFT;
		cfg_data = '0;
		errors = 0;
		quiet = 0;
		hold_long = 0;
		sent_cnt = 0;
		foreach (coef_mem[i]) coef_mem[i] = '0;
		vp_left = 0;
		vp_top = 0;
		vp_width = 1920;
		vp_height = 1080;
		w_min = 655;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows.push_back('{proj_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1, z});
		rows.push_back('{load_beat(11, 32'h0001_0000), 1'b0, z});
		rows.push_back('{load_beat(12, 32'h7FFF_FFFF), 1'b0, z});
		rows.push_back('{load_beat(15, 32'h8000_0000), 1'b0, z});
		rows.push_back('{proj_beat(0, 0, 0), 1'b1,
			'{1'b1, 32'sd960 * 65536 + 32768, 32'sd540 * 65536 - 32768}});
		rows.push_back('{load_beat(0, 32'h0001_0000), 1'b0, z});
		rows.push_back('{load_beat(5, 32'h0001_0000), 1'b0, z});
		rows.push_back('{load_beat(10, 32'h0001_0000), 1'b0, z});
		rows.push_back('{proj_beat(32'h7FFF_FFFF, 32'h8000_0000, 0), 1'b0, z});
		rows.push_back('{proj_beat(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000), 1'b0, z});
		rows.push_back('{load_beat(11, 32'h0000_0000), 1'b0, z});
		rows.push_back('{proj_beat(0, 0, 32'h8000_0000), 1'b1, z});
		rows.push_back('{proj_beat(0, 0, 32'h0000_028F), 1'b0, z});
		rows.push_back('{proj_beat(0, 0, 32'h0000_028E), 1'b1, z});
		rows.push_back('{load_beat(11, 32'h7FFF_FFFF), 1'b0, z});
		rows.push_back('{proj_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, z});
		rows.push_back('{load_beat(3, 32'h7FFF_FFFF), 1'b0, z});
		rows.push_back('{load_beat(7, 32'h8000_0000), 1'b0, z});
		rows.push_back('{load_beat(11, 32'h0000_0001), 1'b0, z});
		rows.push_back('{proj_beat(0, 0, 0), 1'b0, z});
		foreach (rows[i]) send_beat(rows[i].beat, rows[i].chk, rows[i].res);
		drain_pipe();

		write_reg(ppp_pkg::REG_W_THRESHOLD, 31'd0);
		send_beat(load_beat(11, 32'h0000_0000), 1'b0, z);
		send_beat(proj_beat(0, 0, 0), 1'b1, z);
		send_beat(load_beat(11, 32'hFFFF_FFFF), 1'b0, z);
		send_beat(proj_beat(0, 0, 0), 1'b1, z);
		drain_pipe();

		write_reg(ppp_pkg::REG_VIEW_LEFT, 31'h7FFF);
		write_reg(ppp_pkg::REG_VIEW_TOP, 31'h8000);
		write_reg(ppp_pkg::REG_VIEW_WIDTH, 31'h3FFF);
		write_reg(ppp_pkg::REG_VIEW_HEIGHT, 31'h3FFF);
		run_random(110);
		drain_pipe();

		write_reg(ppp_pkg::REG_VIEW_LEFT, 31'h8000);
		write_reg(ppp_pkg::REG_VIEW_TOP, 31'h7FFF);
		write_reg(ppp_pkg::REG_VIEW_WIDTH, 31'd0);
		write_reg(ppp_pkg::REG_VIEW_HEIGHT, 31'd1);
		write_reg(ppp_pkg::REG_W_THRESHOLD, 31'h7FFF_FFFF);
		run_random(55);
		drain_pipe();

		for (int p = 0; p < 3; p++) begin
			write_reg(ppp_pkg::REG_VIEW_LEFT, 31'($urandom));
			write_reg(ppp_pkg::REG_VIEW_TOP, 31'($urandom));
			write_reg(ppp_pkg::REG_VIEW_WIDTH, 31'($urandom_range(0, 16383)));
			write_reg(ppp_pkg::REG_VIEW_HEIGHT, 31'($urandom_range(0, 16383)));
			write_reg(ppp_pkg::REG_W_THRESHOLD, 31'($urandom_range(0, 32'h0002_0000)));
			run_random(75);
			drain_pipe();
		end

		write_reg(ppp_pkg::REG_VIEW_LEFT, 31'd0);
		write_reg(ppp_pkg::REG_VIEW_TOP, 31'd0);
		write_reg(ppp_pkg::REG_VIEW_WIDTH, 31'd1920);
		write_reg(ppp_pkg::REG_VIEW_HEIGHT, 31'd1080);
		write_reg(ppp_pkg::REG_W_THRESHOLD, 31'd655);
		hold_long = 1;
		run_random(75);
		hold_long = 0;
		quiet = 1;
		run_random(55);
		drain_pipe();
		if (errors == 0)
			$display("perspective_point_projection_top: match");
		else
			$display("perspective_point_projection_top: mismatch");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				out_stall <= 1'b0;
				while (hold_long) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ppp_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result beat %h", out_data);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (out_data.on_screen !== want.on_screen) begin
					$error("on_screen expected %0d actual %0d", want.on_screen,
						out_data.on_screen);
					errors++;
				end
				if (out_data.screen_x !== want.screen_x) begin
					$error("screen_x expected %0d actual %0d", want.screen_x,
						out_data.screen_x);
					errors++;
				end
				if (out_data.screen_y !== want.screen_y) begin
					$error("screen_y expected %0d actual %0d", want.screen_y,
						out_data.screen_y);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("perspective_point_projection_top: mismatch");
			$finish;
		end
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_dot.sv
hw/rtl/ppp_div.sv
hw/rtl/ppp_view.sv
hw/rtl/perspective_point_projection_top.sv
tb/sv/tb_perspective_point_projection_top.sv
